/* rtl/core/mie_pkg.sv */
package mie_pkg;

   // Width of the value field and of the data words that carry it.
   localparam int DATA_W = 64;
   // Bits of the value that are significant; the value is sign-extended from the top one.
   localparam int VALUE_WIDTH = 64;
   localparam int SEXT_SHIFT = DATA_W - VALUE_WIDTH;
   // Width of the modulus and of every residue.
   localparam int MOD_W = 63;
   // Step counter of the divider: must hold DATA_W itself.
   localparam int CNT_W = $clog2(DATA_W + 1);
   localparam logic [MOD_W-1:0] RESET_MODULUS = MOD_W'(65537);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_EUC_GO,
      ST_EUC_WAIT,
      ST_FIN_GO,
      ST_FIN_WAIT,
      ST_DONE
   } mie_state_type;

   // Command to the shared divider: remainder of dividend by divisor, and the
   // product quotient * coef modulo 2^DATA_W.
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [MOD_W-1:0]  divisor;
      logic [DATA_W-1:0] coef;
   } mie_div_req_type;

   typedef struct packed {
      logic              done;
      logic [MOD_W-1:0]  rem;
      logic [DATA_W-1:0] qs;
   } mie_div_rsp_type;

endpackage

/* rtl/core/mie_divider.sv */
module mie_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  mie_pkg::mie_div_req_type div_req,
   output mie_pkg::mie_div_rsp_type div_rsp
);

   logic [mie_pkg::CNT_W-1:0]  cnt_ff,  cnt_in;
   logic                       done_ff, done_in;
   logic [mie_pkg::MOD_W-1:0]  rem_ff,  rem_in;
   logic [mie_pkg::DATA_W-1:0] dq_ff,   dq_in;
   logic [mie_pkg::MOD_W-1:0]  div_ff,  div_in;
   logic [mie_pkg::DATA_W-1:0] coef_ff, coef_in;
   logic [mie_pkg::DATA_W-1:0] acc_ff,  acc_in;

   logic [mie_pkg::DATA_W-1:0] trial;
   logic [mie_pkg::DATA_W-1:0] diff;
   logic                       fits;

   // Restoring division, one quotient bit per cycle, MSB first. The product
   // quotient * coef is built alongside by Horner's rule.
   always_comb begin
      trial   = {rem_ff, dq_ff[mie_pkg::DATA_W-1]};
      fits    = trial >= {1'b0, div_ff};
      diff    = trial - {1'b0, div_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      div_in  = div_ff;
      coef_in = coef_ff;
      acc_in  = acc_ff;
      if (div_req.start) begin
         cnt_in  = mie_pkg::CNT_W'(mie_pkg::DATA_W);
         rem_in  = '0;
         dq_in   = div_req.dividend;
         div_in  = div_req.divisor;
         coef_in = div_req.coef;
         acc_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == mie_pkg::CNT_W'(1));
         rem_in  = fits ? diff[mie_pkg::MOD_W-1:0] : trial[mie_pkg::MOD_W-1:0];
         dq_in   = {dq_ff[mie_pkg::DATA_W-2:0], 1'b0};
         acc_in  = {acc_ff[mie_pkg::DATA_W-2:0], 1'b0} + (fits ? coef_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      div_ff  <= div_in;
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;
   assign div_rsp.qs   = acc_ff;

endmodule

/* rtl/core/modular_inverse_ext_euclid_core.sv */
// Modular inverse by the extended Euclidean algorithm. Each request beat carries
// a signed value; the core reduces it into [0, p), with p the modulus last written
// on the csr channel (65537 after reset), and runs the extended Euclidean
// algorithm to return the Bezout coefficient of the value reduced into [0, p).
// A value congruent to zero, or a modulus below two, gives inverse zero with the
// zero_error flag set. Values that share a factor with p raise no flag and give a
// coefficient that is not a true inverse. All arithmetic runs on one bit-serial
// divider that yields one quotient bit per cycle and builds quotient times
// coefficient alongside it, so every division takes as long as any other, whatever
// its operands. An item runs the initial reduction, one division per Euclid step
// and the final reduction, plus bookkeeping states; a modulus below two skips all
// divisions, and a value congruent to zero stops after the initial reduction.
// The core accepts no request while an item is in progress; the result sits in
// an output register, so the next request can be accepted while that result
// still waits to be taken. The user must write the modulus only while the core
// is idle; the core itself does not enforce this.
module modular_inverse_ext_euclid_core (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [mie_pkg::DATA_W-1:0] req_tdata,  // [63:0] value (signed)
   // Response channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mie_pkg::DATA_W-1:0] rsp_tdata,  // [62:0] inverse, [63] zero fill
   output logic                       rsp_tuser,  // [0] zero_error
   // Modulus write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mie_pkg::MOD_W-1:0]  csr_data    // modulus p
);

   mie_pkg::mie_state_type st_ff, st_in;

   logic [mie_pkg::MOD_W-1:0]  modulus_ff,  modulus_in;
   logic                       neg_ff,      neg_in;
   logic [mie_pkg::DATA_W-1:0] work_ff,     work_in;
   logic [mie_pkg::MOD_W-1:0]  old_r_ff,    old_r_in;
   logic [mie_pkg::MOD_W-1:0]  r_ff,        r_in;
   logic [mie_pkg::DATA_W-1:0] old_s_ff,    old_s_in;
   logic [mie_pkg::DATA_W-1:0] s_ff,        s_in;
   logic [mie_pkg::MOD_W-1:0]  res_inv_ff,  res_inv_in;
   logic                       res_err_ff,  res_err_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [mie_pkg::MOD_W-1:0]  rsp_inv_ff,  rsp_inv_in;
   logic                       rsp_err_ff,  rsp_err_in;

   logic signed [mie_pkg::DATA_W-1:0] value_shl;
   logic [mie_pkg::DATA_W-1:0] value_ext;
   logic [mie_pkg::DATA_W-1:0] neg_src;
   logic [mie_pkg::DATA_W-1:0] neg_val;
   logic [mie_pkg::MOD_W-1:0]  fixed_rem;

   mie_pkg::mie_div_req_type div_req;
   mie_pkg::mie_div_rsp_type div_rsp;

   mie_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (st_ff == mie_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_inv_ff};
   assign rsp_tuser  = rsp_err_ff;

   always_comb begin
      // Sign-extend the request from its top significant bit.
      value_shl = $signed(req_tdata << mie_pkg::SEXT_SHIFT);
      value_ext = value_shl >>> mie_pkg::SEXT_SHIFT;

      // One negator serves the start of both reductions: a negative operand is
      // reduced by magnitude and the remainder reflected afterwards.
      neg_src = (st_ff == mie_pkg::ST_IDLE) ? value_ext : old_s_ff;
      neg_val = '0 - neg_src;

      // Reflection of a remainder taken from a negative operand: r -> p - r.
      if (neg_ff && (div_rsp.rem != '0)) begin
         fixed_rem = modulus_ff - div_rsp.rem;
      end else begin
         fixed_rem = div_rsp.rem;
      end

      st_in        = st_ff;
      modulus_in   = modulus_ff;
      neg_in       = neg_ff;
      work_in      = work_ff;
      old_r_in     = old_r_ff;
      r_in         = r_ff;
      old_s_in     = old_s_ff;
      s_in         = s_ff;
      res_inv_in   = res_inv_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_inv_in   = rsp_inv_ff;
      rsp_err_in   = rsp_err_ff;

      div_req.start    = 1'b0;
      div_req.dividend = work_ff;
      div_req.divisor  = modulus_ff;
      div_req.coef     = '0;

      if (csr_valid) begin
         modulus_in = csr_data;
      end

      unique case (st_ff)
         mie_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (modulus_ff < mie_pkg::MOD_W'(2)) begin
                  // Moduli zero and one: every residue counts as zero.
                  res_inv_in = '0;
                  res_err_in = 1'b1;
                  st_in      = mie_pkg::ST_DONE;
               end else begin
                  neg_in  = value_ext[mie_pkg::DATA_W-1];
                  work_in = value_ext[mie_pkg::DATA_W-1] ? neg_val : value_ext;
                  st_in   = mie_pkg::ST_RED_GO;
               end
            end
         end
         mie_pkg::ST_RED_GO: begin
            div_req.start = 1'b1;
            st_in         = mie_pkg::ST_RED_WAIT;
         end
         mie_pkg::ST_RED_WAIT: begin
            if (div_rsp.done) begin
               if (fixed_rem == '0) begin
                  res_inv_in = '0;
                  res_err_in = 1'b1;
                  st_in      = mie_pkg::ST_DONE;
               end else begin
                  old_r_in = fixed_rem;
                  r_in     = modulus_ff;
                  old_s_in = mie_pkg::DATA_W'(1);
                  s_in     = '0;
                  st_in    = mie_pkg::ST_EUC_GO;
               end
            end
         end
         mie_pkg::ST_EUC_GO: begin
            if (r_ff == '0) begin
               st_in = mie_pkg::ST_FIN_GO;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b0, old_r_ff};
               div_req.divisor  = r_ff;
               div_req.coef     = s_ff;
               st_in            = mie_pkg::ST_EUC_WAIT;
            end
         end
         mie_pkg::ST_EUC_WAIT: begin
            if (div_rsp.done) begin
               old_r_in = r_ff;
               r_in     = div_rsp.rem;
               old_s_in = s_ff;
               s_in     = old_s_ff - div_rsp.qs;
               st_in    = mie_pkg::ST_EUC_GO;
            end
         end
         mie_pkg::ST_FIN_GO: begin
            // The last coefficient wraps in 64 bits; reduce it like a signed value.
            neg_in           = old_s_ff[mie_pkg::DATA_W-1];
            div_req.start    = 1'b1;
            div_req.dividend = old_s_ff[mie_pkg::DATA_W-1] ? neg_val : old_s_ff;
            st_in            = mie_pkg::ST_FIN_WAIT;
         end
         mie_pkg::ST_FIN_WAIT: begin
            if (div_rsp.done) begin
               res_inv_in = fixed_rem;
               res_err_in = 1'b0;
               st_in      = mie_pkg::ST_DONE;
            end
         end
         mie_pkg::ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_inv_in   = res_inv_ff;
               rsp_err_in   = res_err_ff;
               st_in        = mie_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= mie_pkg::ST_IDLE;
         modulus_ff   <= mie_pkg::RESET_MODULUS;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      work_ff    <= work_in;
      old_r_ff   <= old_r_in;
      r_ff       <= r_in;
      old_s_ff   <= old_s_in;
      s_ff       <= s_in;
      res_inv_ff <= res_inv_in;
      res_err_ff <= res_err_in;
      rsp_inv_ff <= rsp_inv_in;
      rsp_err_ff <= rsp_err_in;
   end

endmodule

/* bench/tb_modular_inverse_ext_euclid_core.sv */
module tb_modular_inverse_ext_euclid_core;

   // Limits of the value field and of the modulus register.
   localparam logic [mie_pkg::DATA_W-1:0] VALUE_MIN =
      {1'b1, {(mie_pkg::DATA_W-1){1'b0}}};
   localparam logic [mie_pkg::DATA_W-1:0] VALUE_MAX =
      {1'b0, {(mie_pkg::DATA_W-1){1'b1}}};
   localparam logic [mie_pkg::DATA_W-1:0] VALUE_ONES  = {mie_pkg::DATA_W{1'b1}};
   localparam logic [mie_pkg::MOD_W-1:0]  MODULUS_MAX = {mie_pkg::MOD_W{1'b1}};

   // The slowest item is a 63-bit modulus with the longest Euclid chain; the drain
   // wait is sized to cover one such item.
   localparam int DRAIN_CYCLES = 7000;
   // The watchdog limit lies well above what roughly 100 items at worst-case latency
   // plus the longest stalls on both sides can take.
   localparam int CYCLE_LIMIT  = 4000000;

   // One result beat as the core should present it.
   typedef struct packed {
      logic [mie_pkg::MOD_W-1:0] inverse;
      logic                      zero_error;
   } inverse_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [mie_pkg::DATA_W-1:0] req_tdata = '0;   // [63:0] value (signed)
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [mie_pkg::DATA_W-1:0] rsp_tdata;        // [62:0] inverse, [63] zero fill
   logic                       rsp_tuser;        // [0] zero_error
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [mie_pkg::MOD_W-1:0]  csr_data = '0;    // modulus p

   // Values waiting to be sent, and inverses waiting to come back, in order.
   logic [mie_pkg::DATA_W-1:0] pending_values[$];
   inverse_result_type         expected_inverses[$];

   // The modulus the core should be using, tracked from csr beats.
   logic [mie_pkg::MOD_W-1:0]  shadow_modulus = mie_pkg::RESET_MODULUS;

   int req_beats_issued = 0;
   int req_beats_taken  = 0;
   int csr_beats        = 0;
   int failures         = 0;
   int cycle_count      = 0;

   int req_gap_left   = 0;
   int rsp_stall_left = 0;
   bit req_steady     = 1'b0;
   bit rsp_steady     = 1'b0;

   modular_inverse_ext_euclid_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A two's complement 64-bit value reduced into [0, m). The magnitude of a
   // negative value is reduced first and then reflected, which stays exact
   // even for the most negative value.
   function automatic logic [63:0] reduce_mod(logic [63:0] v, logic [63:0] m);
      logic [63:0] r;
      if (v[63]) begin
         r = (64'd0 - v) % m;
         return (r != 64'd0) ? m - r : 64'd0;
      end
      return v % m;
   endfunction

   // Expected result for one value under modulus p. The Bezout coefficients
   // are kept modulo 2^64; their true size never exceeds p, so the final
   // signed reduction recovers them exactly.
   function automatic inverse_result_type predict_inverse(
      logic [mie_pkg::DATA_W-1:0] raw, logic [mie_pkg::MOD_W-1:0] p);
      inverse_result_type res;
      logic [63:0] mask, sign, v, m, a, old_r, r, old_s, s, q, nr, ns, coef;
      mask = ((64'd1 << (mie_pkg::VALUE_WIDTH - 1)) << 1) - 64'd1;
      sign = 64'd1 << (mie_pkg::VALUE_WIDTH - 1);
      v = ((64'(raw) & mask) ^ sign) - sign;
      m = 64'(p);
      res.inverse    = '0;
      res.zero_error = 1'b1;
      // A modulus of zero or one makes every residue count as zero.
      if (m < 64'd2) return res;
      a = reduce_mod(v, m);
      if (a == 64'd0) return res;
      old_r = a;
      r     = m;
      old_s = 64'd1;
      s     = 64'd0;
      while (r != 64'd0) begin
         q     = old_r / r;
         nr    = old_r - q * r;
         ns    = old_s - q * s;
         old_r = r;
         r     = nr;
         old_s = s;
         s     = ns;
      end
      // When gcd(a, p) > 1 this is not a true inverse, but it is what comes out.
      coef = reduce_mod(old_s, m);
      res.inverse    = coef[mie_pkg::MOD_W-1:0];
      res.zero_error = 1'b0;
      return res;
   endfunction

   // Idle length for either side: half the time none, mostly a short one,
   // and now and then a long one. In steady mode there is no idling at all.
   function automatic int idle_length(bit steady);
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 10) return 0;
      if (pick < 18) return $urandom_range(1, 3);
      return $urandom_range(40, 300);
   endfunction

   // Random value shaped to hit the interesting residues of modulus p.
   function automatic logic [mie_pkg::DATA_W-1:0] random_value(
      logic [mie_pkg::MOD_W-1:0] p);
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0:       return 64'(p) * 64'($urandom_range(0, 1000));
         1:       return 64'd0 - 64'(p) * 64'($urandom_range(1, 1000));
         2:       return 64'($urandom_range(0, 2000)) - 64'd1000;
         3:       return full * 64'($urandom_range(2, 12));
         4:       return $urandom_range(0, 1) ? VALUE_MAX - 64'($urandom_range(0, 3))
                                              : VALUE_MIN + 64'($urandom_range(0, 3));
         5:       return 64'(p) + 64'($urandom_range(0, 2)) - 64'd1;
         default: return full;
      endcase
   endfunction

   // Blocks until every queued value has been taken and every result checked.
   task automatic wait_drained();
      while (pending_values.size() != 0 || req_beats_taken != req_beats_issued ||
             expected_inverses.size() != 0)
         @(negedge clock);
   endtask

   // The modulus only changes while the core is idle, so the write waits for
   // the pipeline to drain, then holds valid until the monitor sees the beat.
   task automatic write_modulus(logic [mie_pkg::MOD_W-1:0] p);
      int seen;
      wait_drained();
      repeat ($urandom_range(1, 6)) @(negedge clock);
      seen = csr_beats;
      csr_data  <= p;
      csr_valid <= 1'b1;
      @(negedge clock);
      while (csr_beats == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request driver: presents the next pending value once the previous beat
   // has gone through, with a random gap between beats.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_beats_taken == req_beats_issued) begin
         if (req_gap_left > 0) begin
            req_tvalid <= 1'b0;
            req_gap_left--;
         end else if (pending_values.size() != 0) begin
            req_tdata  <= pending_values.pop_front();
            req_tvalid <= 1'b1;
            req_beats_issued++;
            if ($urandom_range(0, 31) == 0) req_steady = !req_steady;
            req_gap_left = idle_length(req_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure: ready drops for random stretches, with long
   // spells of steady readiness mixed in.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
         rsp_stall_left = idle_length(rsp_steady);
      end
   end

   // Monitor: everything is sampled at the rising edge. An accepted request
   // beat is predicted right away against the current modulus; an accepted
   // response beat is checked against the oldest prediction.
   always @(posedge clock) begin : monitor
      inverse_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            shadow_modulus <= csr_data;
            csr_beats      <= csr_beats + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_inverses.push_back(predict_inverse(req_tdata, shadow_modulus));
            req_beats_taken <= req_beats_taken + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_inverses.size() == 0) begin
               $error("result beat with nothing expected: inverse %0d zero_error %0b",
                      rsp_tdata[mie_pkg::MOD_W-1:0], rsp_tuser);
               failures++;
            end else begin
               want = expected_inverses.pop_front();
               if (rsp_tdata[mie_pkg::MOD_W-1:0] !== want.inverse) begin
                  $error("inverse: expected %0d, actual %0d", want.inverse,
                         rsp_tdata[mie_pkg::MOD_W-1:0]);
                  failures++;
               end
               if (rsp_tuser !== want.zero_error) begin
                  $error("zero_error: expected %0b, actual %0b", want.zero_error,
                         rsp_tuser);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      logic [mie_pkg::MOD_W-1:0] p;
      int items;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset modulus 65537: zero, unit, field extremes, multiples of p.
      pending_values = '{64'd0, 64'd1, VALUE_ONES, VALUE_MIN, VALUE_MAX, 64'd65537,
                         64'd0 - 64'd65537, 64'd65536, 64'd2, 64'd131074, 64'd12345};

      // Smallest legal modulus: every odd value inverts to one.
      write_modulus(mie_pkg::MOD_W'(2));
      pending_values = '{64'd0, 64'd1, VALUE_ONES, VALUE_MIN, VALUE_MAX};

      // Moduli below two flag every value.
      write_modulus(mie_pkg::MOD_W'(0));
      pending_values = '{64'd5, 64'd0};
      write_modulus(mie_pkg::MOD_W'(1));
      pending_values = '{64'd7};

      // Largest modulus, which is composite: 49 shares a factor with it, and
      // VALUE_MAX equals it.
      write_modulus(MODULUS_MAX);
      pending_values = '{64'd1, VALUE_MAX, VALUE_ONES, VALUE_MIN, 64'd49, 64'd2};

      // Random phases. Most moduli are small to keep items short; two are
      // full width and carry fewer items.
      for (int phase = 0; phase < 10; phase++) begin
         items = 8;
         case (phase)
            0:       p = mie_pkg::MOD_W'(360);
            1, 6:    p = mie_pkg::MOD_W'($urandom_range(2, 1000));
            2, 8:    p = mie_pkg::MOD_W'($urandom_range(2, 65535));
            3:       p = mie_pkg::MOD_W'($urandom_range(2, 32'hFFFF_FFFF));
            4:       begin
                        p = {1'b1, 30'($urandom), $urandom};
                        items = 7;
                     end
            5:       begin
                        // Even and full width, so many values are not coprime.
                        p = {31'($urandom), $urandom} & ~mie_pkg::MOD_W'(1);
                        if (p < mie_pkg::MOD_W'(2)) p = mie_pkg::MOD_W'(4);
                        items = 7;
                     end
            7:       p = mie_pkg::MOD_W'(($urandom_range(1, 32'h7FFF_FFFF)) * 2);
            default: p = mie_pkg::RESET_MODULUS;
         endcase
         write_modulus(p);
         for (int i = 0; i < items; i++)
            pending_values.push_back(random_value(p));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_inverses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
